// ----- rtl/core/tavs_pkg.sv -----
// ----------------------------------------------------------------------------
// tavs_pkg - shared types and constants
// Widths, reset values, register indexes, status codes and the controller
// state type of the trimmed average voltage scaler.
// ----------------------------------------------------------------------------
package tavs_pkg;

  // default batch depth
  localparam int MAX_SAMPLES_DEF = 10;

  // field widths
  localparam int SAMPLE_W = 10;
  localparam int STATUS_W = 2;
  localparam int VOLT_W   = 29;

  // register widths
  localparam int SCNT_W = 4;
  localparam int REF_W  = 13;
  localparam int RES_W  = 16;

  // register reset values
  localparam logic [SCNT_W-1:0] SCNT_RST  = 4'd6;
  localparam logic [REF_W-1:0]  REF_RST   = 13'd3300;
  localparam logic [RES_W-1:0]  UPPER_RST = 16'd300;
  localparam logic [RES_W-1:0]  LOWER_RST = 16'd51;

  // register indexes (word address bits)
  localparam logic [1:0] REG_SAMPLE_COUNT  = 2'd0;
  localparam logic [1:0] REG_REFERENCE_MV  = 2'd1;
  localparam logic [1:0] REG_DIVIDER_UPPER = 2'd2;
  localparam logic [1:0] REG_DIVIDER_LOWER = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_READ_ERROR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_COUNT  = 2'd2;

  // shared divider: dividend and divisor widths
  localparam int DIV_DW = 30;
  localparam int DIV_VW = 16;
  localparam int DCNT_W = 5;

  // converter full scale
  localparam logic [DIV_VW-1:0] ADC_FULL_SCALE = 16'd1023;

  // reciprocal of full scale: ceil(2^33 / 1023), exact for dividends below 2^23
  localparam logic [23:0] ADC_RECIP    = 24'd8396809;
  localparam int          ADC_RECIP_SH = 33;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_MM,
    ST_SCAN_SUM,
    ST_DIV_AVG,
    ST_MUL_REF,
    ST_DIV_ADC,
    ST_MUL_RES,
    ST_DIV_RES,
    ST_EMIT
  } tavs_state_t;

endpackage

// ----- rtl/core/tavs_ram.sv -----
// ----------------------------------------------------------------------------
// tavs_ram - generic single-port-write ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tavs_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/trimmed_average_voltage_scaler.sv -----
// ----------------------------------------------------------------------------
// trimmed_average_voltage_scaler - trimmed mean adc filter with mv scaling
// Collects a batch of adc samples in a small ram, drops the batch extremes,
// averages the rest and scales the average to millivolts through a divider.
//
//   port group    dir   carries
//   s_*           in    sample items: tdata = sample, tuser = read_failed
//   m_*           out   result items: tdata = average_raw, scaled_mv;
//                                     tuser = status
//   p* (apb)      in    sample_count, reference_mv, divider_upper,
//                       divider_lower at byte addresses 0, 4, 8, 12
//
// an item that does not close a batch leaves s_tready high; an error item goes
// straight to the emit step and reaches the output register once it is free.
// after a closing item s_tready stays low through two ram passes, two 30-step
// divisions on one shared restoring divider, a reciprocal multiply for the
// full-scale step and the emit step; the average division is skipped when
// nothing survives trimming and the resistor division when the lower
// resistor is 0. a result still waiting in the output register holds the
// emit step; reset is synchronous and the sample ram needs no clearing pass.
// ----------------------------------------------------------------------------
module trimmed_average_voltage_scaler #(
  parameter int MAX_SAMPLES = tavs_pkg::MAX_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // sample stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] sample
  input  logic [0:0]  s_tuser,   // [0] read_failed
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [9:0] average_raw, [38:10] scaled_mv
  output logic [1:0]  m_tuser,   // [1:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CMP_W  = (CNT_W > tavs_pkg::SCNT_W) ? CNT_W : tavs_pkg::SCNT_W;
  localparam int SUM_W  = $clog2(MAX_SAMPLES * 1023 + 1);
  localparam int DW     = tavs_pkg::DIV_DW;
  localparam int VW     = tavs_pkg::DIV_VW;
  localparam int SW     = tavs_pkg::SAMPLE_W;

  // configuration registers
  logic [tavs_pkg::SCNT_W-1:0] sample_count;
  logic [tavs_pkg::REF_W-1:0]  reference_mv;
  logic [tavs_pkg::RES_W-1:0]  divider_upper;
  logic [tavs_pkg::RES_W-1:0]  divider_lower;

  // control
  tavs_pkg::tavs_state_t state, state_next;
  logic [CNT_W-1:0]  samples_taken;
  logic [CNT_W-1:0]  batch_n;
  logic [CNT_W-1:0]  rd_cnt;
  logic              rd_pend;

  // datapath
  logic [SW-1:0]     hi, lo;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  kept;
  logic [DW-1:0]     div_quo;
  logic [VW-1:0]     div_rem;
  logic [VW-1:0]     div_dvs;
  logic [tavs_pkg::DCNT_W-1:0] div_cnt;
  logic [tavs_pkg::STATUS_W-1:0] res_status;
  logic [SW-1:0]     res_avg;
  logic [tavs_pkg::VOLT_W-1:0] res_mv;

  // decoded conditions
  logic              accept, bad_count, read_fail, wrap, batch_close;
  logic [CNT_W-1:0]  taken_eff, taken_inc;
  logic              scan_issue, scan_done, div_last, trim, drop;
  logic              out_free, emit_load, ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [SW-1:0]     ram_rdata;
  logic              cfg_we;

  // sample ram
  tavs_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(s_tdata[SW-1:0]),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // apb register port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= tavs_pkg::SCNT_RST;
      reference_mv  <= tavs_pkg::REF_RST;
      divider_upper <= tavs_pkg::UPPER_RST;
      divider_lower <= tavs_pkg::LOWER_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        tavs_pkg::REG_SAMPLE_COUNT:  sample_count  <= pwdata[tavs_pkg::SCNT_W-1:0];
        tavs_pkg::REG_REFERENCE_MV:  reference_mv  <= pwdata[tavs_pkg::REF_W-1:0];
        tavs_pkg::REG_DIVIDER_UPPER: divider_upper <= pwdata[tavs_pkg::RES_W-1:0];
        tavs_pkg::REG_DIVIDER_LOWER: divider_lower <= pwdata[tavs_pkg::RES_W-1:0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    case (paddr[3:2])
      tavs_pkg::REG_SAMPLE_COUNT:  prdata = 32'(sample_count);
      tavs_pkg::REG_REFERENCE_MV:  prdata = 32'(reference_mv);
      tavs_pkg::REG_DIVIDER_UPPER: prdata = 32'(divider_upper);
      tavs_pkg::REG_DIVIDER_LOWER: prdata = 32'(divider_lower);
      default:                     prdata = '0;
    endcase
  end

  // input item decode
  assign accept    = s_tvalid & s_tready;
  assign bad_count = (sample_count == '0) ||
                     (CMP_W'(sample_count) > CMP_W'(MAX_SAMPLES));
  assign read_fail = s_tuser[0];
  assign wrap      = samples_taken >= CNT_W'(MAX_SAMPLES);
  assign taken_eff = wrap ? '0 : samples_taken;
  assign taken_inc = taken_eff + CNT_W'(1);
  assign batch_close = CMP_W'(taken_inc) >= CMP_W'(sample_count);
  assign ram_waddr = taken_eff[ADDR_W-1:0];

  // ram scan pointer
  assign scan_issue = rd_cnt != batch_n;
  assign scan_done  = !scan_issue && !rd_pend;
  assign ram_raddr  = rd_cnt[ADDR_W-1:0];
  assign trim       = batch_n > CNT_W'(2);
  assign drop       = trim && ((ram_rdata == hi) || (ram_rdata == lo));

  // shared restoring divider step
  logic [VW:0]   div_sh, div_diff;
  logic          div_ge;
  logic [VW-1:0] div_rem_step;
  logic [DW-1:0] div_quo_step;

  always_comb begin
    div_sh       = {div_rem, div_quo[DW-1]};
    div_diff     = div_sh - {1'b0, div_dvs};
    div_ge       = div_sh >= {1'b0, div_dvs};
    div_rem_step = div_ge ? div_diff[VW-1:0] : div_sh[VW-1:0];
    div_quo_step = {div_quo[DW-2:0], div_ge};
  end

  assign div_last = div_cnt == tavs_pkg::DCNT_W'(DW - 1);

  // multipliers, each loads straight into the divider registers
  logic [22:0] prod_ref;
  logic [16:0] res_sum;
  logic [DW-1:0] prod_res;

  assign prod_ref = 23'(res_avg) * 23'(reference_mv);
  assign res_sum  = 17'(divider_upper) + 17'(divider_lower);
  assign prod_res = DW'(div_quo[12:0]) * DW'(res_sum);

  // full-scale division by reciprocal multiply
  logic [46:0] adc_prod;
  logic [12:0] adc_quo;

  assign adc_prod = 47'(div_quo[22:0]) * 47'(tavs_pkg::ADC_RECIP);
  assign adc_quo  = adc_prod[tavs_pkg::ADC_RECIP_SH+12:tavs_pkg::ADC_RECIP_SH];

  // output register
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tavs_pkg::ST_IDLE: begin
        if (accept) begin
          if (bad_count || read_fail) begin
            state_next = tavs_pkg::ST_EMIT;
          end else if (batch_close) begin
            state_next = tavs_pkg::ST_SCAN_MM;
          end
        end
      end
      tavs_pkg::ST_SCAN_MM: begin
        if (scan_done) state_next = tavs_pkg::ST_SCAN_SUM;
      end
      tavs_pkg::ST_SCAN_SUM: begin
        if (scan_done) begin
          state_next = (kept == '0) ? tavs_pkg::ST_MUL_REF : tavs_pkg::ST_DIV_AVG;
        end
      end
      tavs_pkg::ST_DIV_AVG: begin
        if (div_last) state_next = tavs_pkg::ST_MUL_REF;
      end
      tavs_pkg::ST_MUL_REF: state_next = tavs_pkg::ST_DIV_ADC;
      tavs_pkg::ST_DIV_ADC: state_next = tavs_pkg::ST_MUL_RES;
      tavs_pkg::ST_MUL_RES: begin
        state_next = (divider_lower == '0) ? tavs_pkg::ST_EMIT : tavs_pkg::ST_DIV_RES;
      end
      tavs_pkg::ST_DIV_RES: begin
        if (div_last) state_next = tavs_pkg::ST_EMIT;
      end
      tavs_pkg::ST_EMIT: begin
        if (out_free) state_next = tavs_pkg::ST_IDLE;
      end
      default: state_next = tavs_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready  = 1'b0;
    emit_load = 1'b0;
    case (state)
      tavs_pkg::ST_IDLE: s_tready  = 1'b1;
      tavs_pkg::ST_EMIT: emit_load = out_free;
      default: ;
    endcase
  end

  assign ram_we = accept && !bad_count && !read_fail;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tavs_pkg::ST_IDLE;
      samples_taken <= '0;
      rd_cnt        <= '0;
      rd_pend       <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;

      // batch fill count
      if (accept) begin
        if (bad_count || read_fail || batch_close) begin
          samples_taken <= '0;
        end else begin
          samples_taken <= taken_inc;
        end
      end

      // scan pointer for both passes
      if (state == tavs_pkg::ST_SCAN_MM || state == tavs_pkg::ST_SCAN_SUM) begin
        if (scan_done) begin
          rd_cnt  <= '0;
          rd_pend <= 1'b0;
        end else begin
          rd_pend <= scan_issue;
          if (scan_issue) rd_cnt <= rd_cnt + CNT_W'(1);
        end
      end

      // result handshake
      if (emit_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      tavs_pkg::ST_IDLE: begin
        if (accept) begin
          res_avg <= '0;
          res_mv  <= '0;
          hi      <= '0;
          lo      <= '1;
          sum     <= '0;
          kept    <= '0;
          batch_n <= taken_inc;
          if (bad_count) begin
            res_status <= tavs_pkg::STATUS_BAD_COUNT;
          end else if (read_fail) begin
            res_status <= tavs_pkg::STATUS_READ_ERROR;
          end else begin
            res_status <= tavs_pkg::STATUS_OK;
          end
        end
      end
      // pass one: batch maximum and minimum
      tavs_pkg::ST_SCAN_MM: begin
        if (rd_pend) begin
          if (ram_rdata > hi) hi <= ram_rdata;
          if (ram_rdata < lo) lo <= ram_rdata;
        end
      end
      // pass two: sum of kept samples, then load the average division
      tavs_pkg::ST_SCAN_SUM: begin
        if (rd_pend && !drop) begin
          sum  <= sum + SUM_W'(ram_rdata);
          kept <= kept + CNT_W'(1);
        end
        if (scan_done) begin
          div_quo <= DW'(sum);
          div_rem <= '0;
          div_dvs <= VW'(kept);
          div_cnt <= '0;
        end
      end
      tavs_pkg::ST_DIV_AVG: begin
        div_quo <= div_quo_step;
        div_rem <= div_rem_step;
        div_cnt <= div_cnt + tavs_pkg::DCNT_W'(1);
        if (div_last) res_avg <= div_quo_step[SW-1:0];
      end
      // avg * reference, then divide by full scale
      tavs_pkg::ST_MUL_REF: begin
        div_quo <= DW'(prod_ref);
      end
      tavs_pkg::ST_DIV_ADC: begin
        div_quo <= DW'(adc_quo);
      end
      // times divider total, then divide by the lower resistor
      tavs_pkg::ST_MUL_RES: begin
        div_quo <= prod_res;
        div_rem <= '0;
        div_dvs <= divider_lower;
        div_cnt <= '0;
        if (divider_lower == '0) res_mv <= '1;
      end
      tavs_pkg::ST_DIV_RES: begin
        div_quo <= div_quo_step;
        div_rem <= div_rem_step;
        div_cnt <= div_cnt + tavs_pkg::DCNT_W'(1);
        if (div_last) begin
          res_mv <= div_quo_step[DW-1] ? '1 : div_quo_step[tavs_pkg::VOLT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit_load) begin
      m_tuser <= res_status;
      m_tdata <= {1'b0, res_mv, res_avg};
    end
  end

endmodule

// ----- verif/tb_trimmed_average_voltage_scaler.sv -----
// ----------------------------------------------------------------------------
// tb_trimmed_average_voltage_scaler - self-checking bench for the scaler
// Sends sample items through the stream port and checks every reading against
// a behavioral trimmed-mean predictor kept in the bench, or a typed row's own
// reading. A short table covers error codes and extremes, then random phases
// run with new register settings each time. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_trimmed_average_voltage_scaler;

  localparam int DEPTH      = tavs_pkg::MAX_SAMPLES_DEF;
  localparam int SETTLE     = 2 * DEPTH + 100;
  localparam int QUIET_MAX  = 4000;
  localparam int PHASES     = 30;

  // one reading as it leaves the block
  typedef struct packed {
    logic [tavs_pkg::STATUS_W-1:0] status;
    logic [tavs_pkg::SAMPLE_W-1:0] average_raw;
    logic [tavs_pkg::VOLT_W-1:0]   scaled_mv;
  } reading_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  // one row of the directed table
  typedef struct packed {
    row_kind_t                     kind;
    logic [1:0]                    reg_idx;
    logic [31:0]                   value;
    logic [tavs_pkg::SAMPLE_W-1:0] smp;
    logic                          fail;
    logic                          typed;
    reading_t                      want;
  } plan_row_t;

  localparam reading_t EXP_EMPTY = {tavs_pkg::STATUS_OK, 10'd0, 29'd0};
  localparam reading_t EXP_ERR   = {tavs_pkg::STATUS_READ_ERROR, 10'd0, 29'd0};
  localparam reading_t EXP_BAD   = {tavs_pkg::STATUS_BAD_COUNT, 10'd0, 29'd0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;    // [9:0] sample
  logic [0:0]  s_tuser = '0;    // [0] read_failed
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // [9:0] average_raw, [38:10] scaled_mv
  logic [1:0]  m_tuser;         // [1:0] status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of registers and batch
  logic [tavs_pkg::SCNT_W-1:0]   batch_len = tavs_pkg::SCNT_RST;
  logic [tavs_pkg::REF_W-1:0]    vref_mv   = tavs_pkg::REF_RST;
  logic [tavs_pkg::RES_W-1:0]    r_upper   = tavs_pkg::UPPER_RST;
  logic [tavs_pkg::RES_W-1:0]    r_lower   = tavs_pkg::LOWER_RST;
  logic [tavs_pkg::SAMPLE_W-1:0] batch_buf [DEPTH];
  int unsigned                   batch_fill = 0;

  reading_t    expected_readings [$];
  reading_t    got_reading;
  reading_t    want_reading;
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned readings_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned idle_pct = 8;
  int unsigned quiet_cycles = 0;

  trimmed_average_voltage_scaler u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // behavioral filter: takes one sample item, returns 1 when a reading comes out
  function automatic bit next_reading(input logic [tavs_pkg::SAMPLE_W-1:0] smp,
                                      input logic fail, output reading_t r);
    logic [tavs_pkg::SAMPLE_W-1:0] hi;
    logic [tavs_pkg::SAMPLE_W-1:0] lo;
    int unsigned                   sum;
    int unsigned                   kept;
    int unsigned                   n;
    logic [63:0]                   t;
    r = '0;
    if (batch_len == 0 || batch_len > DEPTH) begin
      batch_fill = 0;
      r.status = tavs_pkg::STATUS_BAD_COUNT;
      return 1'b1;
    end
    if (fail) begin
      batch_fill = 0;
      r.status = tavs_pkg::STATUS_READ_ERROR;
      return 1'b1;
    end
    if (batch_fill >= DEPTH) batch_fill = 0;
    batch_buf[batch_fill] = smp;
    batch_fill++;
    if (batch_fill < batch_len) return 1'b0;
    n = batch_fill;
    batch_fill = 0;
    // batch extremes
    hi = '0;
    lo = '1;
    for (int i = 0; i < n; i++) begin
      if (batch_buf[i] > hi) hi = batch_buf[i];
      if (batch_buf[i] < lo) lo = batch_buf[i];
    end
    // mean of what survives trimming
    sum = 0;
    kept = 0;
    for (int i = 0; i < n; i++) begin
      if (!(n > 2 && (batch_buf[i] == hi || batch_buf[i] == lo))) begin
        sum += batch_buf[i];
        kept++;
      end
    end
    r.status = tavs_pkg::STATUS_OK;
    r.average_raw = (kept != 0) ? tavs_pkg::SAMPLE_W'(sum / kept) : '0;
    // divider scaling, truncating at each step
    if (r_lower == 0) begin
      r.scaled_mv = '1;
    end else begin
      t = 64'(r.average_raw) * 64'(vref_mv);
      t = t / 64'(tavs_pkg::ADC_FULL_SCALE);
      t = t * (64'(r_upper) + 64'(r_lower));
      t = t / 64'(r_lower);
      r.scaled_mv = (t > 64'h1FFF_FFFF) ? '1 : tavs_pkg::VOLT_W'(t);
    end
    return 1'b1;
  endfunction

  function automatic plan_row_t cfg_row(input logic [1:0] idx, input int unsigned val);
    cfg_row = '0;
    cfg_row.kind = ROW_CFG;
    cfg_row.reg_idx = idx;
    cfg_row.value = val;
  endfunction

  function automatic plan_row_t item_row(input int unsigned smp, input logic fail);
    item_row = '0;
    item_row.kind = ROW_ITEM;
    item_row.smp = tavs_pkg::SAMPLE_W'(smp);
    item_row.fail = fail;
  endfunction

  function automatic plan_row_t typed_row(input int unsigned smp, input logic fail,
                                          input reading_t want);
    typed_row = item_row(smp, fail);
    typed_row.typed = 1'b1;
    typed_row.want = want;
  endfunction

  // send one sample item, predicting at the accepting edge
  task automatic push_sample(input logic [tavs_pkg::SAMPLE_W-1:0] smp, input logic fail,
                             input logic typed, input reading_t want);
    reading_t r;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, smp};
    s_tuser <= fail;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (next_reading(smp, fail, r)) expected_readings.push_back(typed ? want : r);
    items_sent++;
  endtask

  // hold off until every reading is back and the block has gone quiet
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write followed by a read back of the same register
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] masked;
    case (idx)
      tavs_pkg::REG_SAMPLE_COUNT:  masked = val & 32'hF;
      tavs_pkg::REG_REFERENCE_MV:  masked = val & 32'h1FFF;
      default:                     masked = val & 32'hFFFF;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      tavs_pkg::REG_SAMPLE_COUNT:  batch_len = tavs_pkg::SCNT_W'(masked);
      tavs_pkg::REG_REFERENCE_MV:  vref_mv = tavs_pkg::REF_W'(masked);
      tavs_pkg::REG_DIVIDER_UPPER: r_upper = tavs_pkg::RES_W'(masked);
      tavs_pkg::REG_DIVIDER_LOWER: r_lower = tavs_pkg::RES_W'(masked);
      default: ;
    endcase
    reg_writes++;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== masked)
      flag_mismatch($sformatf("register %0d reads %0d, wrote %0d", idx, prdata, masked));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // receiver with random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // compare each accepted reading with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_reading = {m_tuser, m_tdata[9:0], m_tdata[38:10]};
      readings_seen++;
      if (expected_readings.size() == 0) begin
        flag_mismatch($sformatf("unexpected reading status %0d avg %0d mv %0d",
                                got_reading.status, got_reading.average_raw,
                                got_reading.scaled_mv));
      end else begin
        want_reading = expected_readings.pop_front();
        if (got_reading.status !== want_reading.status)
          flag_mismatch($sformatf("status %0d, want %0d",
                                  got_reading.status, want_reading.status));
        if (got_reading.average_raw !== want_reading.average_raw)
          flag_mismatch($sformatf("average_raw %0d, want %0d",
                                  got_reading.average_raw, want_reading.average_raw));
        if (got_reading.scaled_mv !== want_reading.scaled_mv)
          flag_mismatch($sformatf("scaled_mv %0d, want %0d",
                                  got_reading.scaled_mv, want_reading.scaled_mv));
      end
    end
  end

  // watchdog on cycles with no traffic anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_MAX) begin
        $display("watchdog: no traffic for %0d cycles", QUIET_MAX);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t   plan [$];
    int unsigned n_items;
    int unsigned base;
    int unsigned alt;
    int unsigned cnt;
    logic [tavs_pkg::SAMPLE_W-1:0] smp;
    reading_t    dummy;

    dummy = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table, starting from reset settings (6 samples, 3300 mV, 300/51)
    plan = '{
      typed_row(0, 1'b1, EXP_ERR),
      item_row(0, 1'b0), item_row(1023, 1'b0), typed_row(512, 1'b1, EXP_ERR),
      item_row(0, 1'b0), item_row(1023, 1'b0), item_row(512, 1'b0),
      item_row(300, 1'b0), item_row(700, 1'b0), item_row(1, 1'b0),
      cfg_row(tavs_pkg::REG_SAMPLE_COUNT, 1),
      item_row(1023, 1'b0), typed_row(0, 1'b0, EXP_EMPTY),
      // everything equals an extreme, nothing left
      cfg_row(tavs_pkg::REG_SAMPLE_COUNT, 3),
      item_row(5, 1'b0), item_row(9, 1'b0), typed_row(5, 1'b0, EXP_EMPTY),
      // count lowered while a batch is partly full
      cfg_row(tavs_pkg::REG_SAMPLE_COUNT, 10),
      item_row(1, 1'b0), item_row(2, 1'b0), item_row(3, 1'b0),
      cfg_row(tavs_pkg::REG_SAMPLE_COUNT, 3),
      item_row(1000, 1'b0),
      // invalid counts win over a read failure
      cfg_row(tavs_pkg::REG_SAMPLE_COUNT, 0),
      typed_row(100, 1'b0, EXP_BAD), typed_row(100, 1'b1, EXP_BAD),
      cfg_row(tavs_pkg::REG_SAMPLE_COUNT, 15),
      typed_row(7, 1'b0, EXP_BAD),
      cfg_row(tavs_pkg::REG_SAMPLE_COUNT, 11),
      typed_row(7, 1'b0, EXP_BAD),
      // register extremes
      cfg_row(tavs_pkg::REG_SAMPLE_COUNT, 1), cfg_row(tavs_pkg::REG_REFERENCE_MV, 8191),
      cfg_row(tavs_pkg::REG_DIVIDER_UPPER, 65535), cfg_row(tavs_pkg::REG_DIVIDER_LOWER, 1),
      item_row(1023, 1'b0),
      cfg_row(tavs_pkg::REG_REFERENCE_MV, 5000),
      typed_row(1023, 1'b0, {tavs_pkg::STATUS_OK, 10'd1023, 29'd327680000}),
      // zero lower resistor saturates the voltage
      cfg_row(tavs_pkg::REG_DIVIDER_LOWER, 0),
      typed_row(1023, 1'b0, {tavs_pkg::STATUS_OK, 10'd1023, 29'h1FFF_FFFF}),
      cfg_row(tavs_pkg::REG_REFERENCE_MV, 0), cfg_row(tavs_pkg::REG_DIVIDER_LOWER, 65535),
      typed_row(1023, 1'b0, {tavs_pkg::STATUS_OK, 10'd1023, 29'd0}),
      cfg_row(tavs_pkg::REG_SAMPLE_COUNT, 2), cfg_row(tavs_pkg::REG_REFERENCE_MV, 5000),
      cfg_row(tavs_pkg::REG_DIVIDER_UPPER, 0),
      item_row(1023, 1'b0), item_row(0, 1'b0)
    };
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        push_sample(plan[i].smp, plan[i].fail, plan[i].typed, plan[i].want);
      end
    end

    // random phases, each with fresh register settings
    for (int phase = 0; phase < PHASES; phase++) begin
      idle_pct = (phase >= 12 && phase < 17) ? 0 : 8;
      wait_drained();
      case ($urandom_range(9))
        7:       cnt = ($urandom_range(1)) ? 1 : DEPTH;
        8:       cnt = ($urandom_range(1)) ? 0 : $urandom_range(DEPTH + 1, 15);
        9:       cnt = 3;
        default: cnt = $urandom_range(1, DEPTH);
      endcase
      write_reg(tavs_pkg::REG_SAMPLE_COUNT, cnt);
      case ($urandom_range(7))
        0:       write_reg(tavs_pkg::REG_REFERENCE_MV, 0);
        1:       write_reg(tavs_pkg::REG_REFERENCE_MV, 5000);
        2:       write_reg(tavs_pkg::REG_REFERENCE_MV, 8191);
        default: write_reg(tavs_pkg::REG_REFERENCE_MV, $urandom_range(0, 8191));
      endcase
      case ($urandom_range(7))
        0:       write_reg(tavs_pkg::REG_DIVIDER_UPPER, 0);
        1:       write_reg(tavs_pkg::REG_DIVIDER_UPPER, 65535);
        default: write_reg(tavs_pkg::REG_DIVIDER_UPPER, $urandom_range(0, 65535));
      endcase
      case ($urandom_range(15))
        0:       write_reg(tavs_pkg::REG_DIVIDER_LOWER, 0);
        1:       write_reg(tavs_pkg::REG_DIVIDER_LOWER, 1);
        2:       write_reg(tavs_pkg::REG_DIVIDER_LOWER, 65535);
        default: write_reg(tavs_pkg::REG_DIVIDER_LOWER, $urandom_range(1, 65535));
      endcase
      // phase lengths rarely divide the batch size, so batches get cut short
      n_items = $urandom_range(15, 45);
      base = $urandom_range(0, 1020);
      alt = $urandom_range(0, 1023);
      for (int k = 0; k < n_items; k++) begin
        case ($urandom_range(3))
          0, 1:    smp = tavs_pkg::SAMPLE_W'($urandom_range(0, 1023));
          2:       smp = tavs_pkg::SAMPLE_W'(base + $urandom_range(0, 3));
          default: smp = tavs_pkg::SAMPLE_W'(($urandom_range(1)) ? base : alt);
        endcase
        push_sample(smp, ($urandom_range(99) < 3), 1'b0, dummy);
        if ($urandom_range(99) < 2) wait_drained();
      end
    end

    wait_drained();
    $display("covered %0d sample items, %0d readings, %0d register writes",
             items_sent, readings_seen, reg_writes);
    $display("settings included invalid counts, zero and full-scale dividers, random stalls");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
